>>> hw/rtl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer package
// Command codes, symbol codes, register indexes and timing types.
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int MAX_SYMBOLS = 32;

    localparam int PERIOD_W  = 16;
    localparam int PATTERN_W = 64;
    localparam int LENGTH_W  = 6;
    localparam int TICKS_W   = 17;
    localparam int PASSES_W  = 8;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICKS_W-1:0] DIV3_MUL   = 17'd43691;
    localparam int                 DIV3_SHIFT = 17;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd500;
    localparam logic [LENGTH_W-1:0]  LENGTH_RESET = 6'd1;
    localparam logic [LENGTH_W-1:0]  LENGTH_MAX   = LENGTH_W'(MAX_SYMBOLS);

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_START    = 2'd1,
        CMD_STOP     = 2'd2,
        CMD_STOP_NOW = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SYM_DASH  = 2'd0,
        SYM_DOT   = 2'd1,
        SYM_SPACE = 2'd2,
        SYM_KEEP  = 2'd3
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLINK_PERIOD    = 2'd0,
        REG_PATTERN_SYMBOLS = 2'd1,
        REG_PATTERN_LENGTH  = 2'd2,
        REG_UNUSED          = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TICKS_W-1:0] on_ticks;
        logic [TICKS_W-1:0] off_ticks;
    } times_t;

endpackage

>>> hw/rtl/led_blink_pattern_sequencer.sv
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle while out_ready holds; the output register frees as it is taken.
// Every item produces exactly one result, computed in a single registered pass.
// Reset: asynchronous, active low; the sequencer goes idle with its lamp state off (led_on
// is not reset); configuration registers return to period 500, all-dash pattern, length 1.
// ----------------------------------------------------------------------------
// LED blink pattern sequencer
// Plays a stored pattern of dash, dot, space and keep symbols on an LED, one step
// per tick or command, with repeat, stop after pass and immediate stop.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [lbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbps_pkg::PATTERN_W-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [lbps_pkg::PASSES_W-1:0]        repeat_count,
    input  logic                                 endless,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 led_on,
    output logic                                 running,
    output logic [lbps_pkg::POS_W-1:0]           symbol_index
);

    logic [lbps_pkg::PERIOD_W-1:0]  blink_period_reg;
    logic [lbps_pkg::PATTERN_W-1:0] pattern_reg;
    logic [lbps_pkg::LENGTH_W-1:0]  length_reg;

    logic [lbps_pkg::PASSES_W-1:0]  passes_reg, passes_next;
    logic                           forever_reg, forever_next;
    logic [lbps_pkg::POS_W-1:0]     position_reg, position_next;
    logic                           on_phase_reg, on_phase_next;
    logic                           lamp_reg, lamp_next;
    logic [lbps_pkg::TICKS_W-1:0]   elapsed_reg, elapsed_next;
    lbps_pkg::times_t               times_reg, times_next;

    logic                           out_valid_reg;
    logic                           led_on_reg;
    logic                           running_reg;
    logic [lbps_pkg::POS_W-1:0]     index_reg;

    logic                           in_xfer;
    logic                           is_running;
    logic [lbps_pkg::LENGTH_W-1:0]  eff_length;
    logic [32:0]                    div3_prod;
    logic [lbps_pkg::PERIOD_W-1:0]  period_div3;
    logic [lbps_pkg::TICKS_W-1:0]   dash_on;
    logic [lbps_pkg::TICKS_W-1:0]   half_period;
    logic [lbps_pkg::TICKS_W-1:0]   full_period;
    logic [lbps_pkg::LENGTH_W-1:0]  pos_plus_one;

    logic [lbps_pkg::PASSES_W-1:0]  pre_passes;
    logic                           pre_forever;
    logic [lbps_pkg::POS_W-1:0]     pre_position;
    logic                           pre_on_phase;
    logic                           pre_lamp;
    logic [lbps_pkg::TICKS_W-1:0]   pre_elapsed;
    lbps_pkg::times_t               pre_times;
    logic                           do_phase;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_xfer    = in_valid && in_ready;
    assign is_running = (passes_reg != '0) || forever_reg;

    assign div3_prod   = 33'(blink_period_reg) * 33'(lbps_pkg::DIV3_MUL);
    assign period_div3 = div3_prod[lbps_pkg::DIV3_SHIFT +: lbps_pkg::PERIOD_W];
    assign full_period = lbps_pkg::TICKS_W'(blink_period_reg);
    assign half_period = lbps_pkg::TICKS_W'(blink_period_reg >> 1);
    assign dash_on     = full_period + half_period;

    always_comb
    begin
        if (length_reg == '0)
        begin
            eff_length = lbps_pkg::LENGTH_W'(1);
        end
        else if (length_reg > lbps_pkg::LENGTH_MAX)
        begin
            eff_length = lbps_pkg::LENGTH_MAX;
        end
        else
        begin
            eff_length = length_reg;
        end
    end

    function automatic lbps_pkg::times_t load_times(
        input logic [lbps_pkg::POS_W-1:0] pos,
        input lbps_pkg::times_t           cur
    );
        lbps_pkg::times_t t;
        lbps_pkg::sym_t   code;
        t    = cur;
        code = lbps_pkg::sym_t'(pattern_reg[{pos, 1'b0} +: 2]);
        case (code)
            lbps_pkg::SYM_DASH:
            begin
                t.on_ticks  = dash_on;
                t.off_ticks = lbps_pkg::TICKS_W'(period_div3);
            end
            lbps_pkg::SYM_DOT:
            begin
                t.on_ticks  = half_period;
                t.off_ticks = half_period;
            end
            lbps_pkg::SYM_SPACE:
            begin
                t.on_ticks  = '0;
                t.off_ticks = full_period;
            end
            default:
            begin
                t = cur;
            end
        endcase
        return t;
    endfunction

    always_comb
    begin
        pre_passes   = passes_reg;
        pre_forever  = forever_reg;
        pre_position = position_reg;
        pre_on_phase = on_phase_reg;
        pre_lamp     = lamp_reg;
        pre_elapsed  = elapsed_reg;
        pre_times    = times_reg;
        do_phase     = 1'b0;
        case (lbps_pkg::cmd_t'(command))
            lbps_pkg::CMD_TICK:
            begin
                if (is_running)
                begin
                    if (elapsed_reg != '1)
                    begin
                        pre_elapsed = elapsed_reg + 1'b1;
                    end
                    do_phase = 1'b1;
                end
            end
            lbps_pkg::CMD_START:
            begin
                pre_passes   = repeat_count;
                pre_forever  = endless;
                pre_position = '0;
                pre_elapsed  = '0;
                pre_on_phase = 1'b1;
                pre_times    = load_times('0, times_reg);
                pre_lamp     = 1'b0;
                do_phase     = 1'b1;
            end
            lbps_pkg::CMD_STOP:
            begin
                pre_passes  = lbps_pkg::PASSES_W'(1);
                pre_forever = 1'b0;
                pre_lamp    = 1'b0;
            end
            default:
            begin
                pre_passes  = '0;
                pre_forever = 1'b0;
                pre_lamp    = 1'b0;
            end
        endcase
    end

    assign pos_plus_one = lbps_pkg::LENGTH_W'(pre_position) + 1'b1;

    always_comb
    begin
        passes_next   = pre_passes;
        forever_next  = pre_forever;
        position_next = pre_position;
        on_phase_next = pre_on_phase;
        lamp_next     = pre_lamp;
        elapsed_next  = pre_elapsed;
        times_next    = pre_times;
        if (do_phase && ((pre_passes != '0) || pre_forever))
        begin
            if (pre_on_phase)
            begin
                if (pre_times.on_ticks == '0)
                begin
                    on_phase_next = 1'b0;
                    elapsed_next  = '0;
                end
                else
                begin
                    lamp_next = 1'b1;
                    if (pre_elapsed >= pre_times.on_ticks)
                    begin
                        on_phase_next = 1'b0;
                        elapsed_next  = '0;
                    end
                end
            end
            else
            begin
                lamp_next = 1'b0;
                if (pre_elapsed >= pre_times.off_ticks)
                begin
                    on_phase_next = 1'b1;
                    elapsed_next  = '0;
                    if (pos_plus_one >= eff_length)
                    begin
                        position_next = '0;
                        if (!pre_forever && (pre_passes != '0))
                        begin
                            passes_next = pre_passes - 1'b1;
                        end
                    end
                    else
                    begin
                        position_next = pos_plus_one[lbps_pkg::POS_W-1:0];
                    end
                    times_next = load_times(position_next, pre_times);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg <= lbps_pkg::PERIOD_RESET;
            pattern_reg      <= '0;
            length_reg       <= lbps_pkg::LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (lbps_pkg::cfg_reg_t'(cfg_index))
                lbps_pkg::REG_BLINK_PERIOD:
                begin
                    blink_period_reg <= cfg_data[lbps_pkg::PERIOD_W-1:0];
                end
                lbps_pkg::REG_PATTERN_SYMBOLS:
                begin
                    pattern_reg <= cfg_data;
                end
                lbps_pkg::REG_PATTERN_LENGTH:
                begin
                    length_reg <= cfg_data[lbps_pkg::LENGTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passes_reg    <= '0;
            forever_reg   <= 1'b0;
            position_reg  <= '0;
            on_phase_reg  <= 1'b0;
            lamp_reg      <= 1'b0;
            elapsed_reg   <= '0;
            times_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                passes_reg   <= passes_next;
                forever_reg  <= forever_next;
                position_reg <= position_next;
                on_phase_reg <= on_phase_next;
                lamp_reg     <= lamp_next;
                elapsed_reg  <= elapsed_next;
                times_reg    <= times_next;
            end
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            led_on_reg  <= lamp_next;
            running_reg <= (passes_next != '0) || forever_next;
            index_reg   <= position_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_on       = led_on_reg;
    assign running      = running_reg;
    assign symbol_index = index_reg;

`ifndef SYNTHESIS
    a_lamp_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        lamp_reg |-> is_running)
        else $error("LED lit while the sequencer is idle");

    a_stop_now_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && command == lbps_pkg::CMD_STOP_NOW) |=> !is_running)
        else $error("Sequencer still running after an immediate stop");

    a_start_endless: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && command == lbps_pkg::CMD_START && endless) |=> forever_reg)
        else $error("Endless start did not set endless mode");

    a_on_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        on_phase_reg |-> (elapsed_reg <= times_reg.on_ticks))
        else $error("On phase ran past its length");

    a_off_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        !on_phase_reg |-> (elapsed_reg <= times_reg.off_ticks))
        else $error("Off phase ran past its length");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg)
        else $error("Input transfer produced no result");
`endif

endmodule
